// ----- hdl/assert_macros.svh -----
// Assertion helpers; clocked on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define XS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define XS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/xs128p_pkg.sv -----
package xs128p_pkg;

    localparam int unsigned WORD_WIDTH  = 64;
    localparam int unsigned OUT_WIDTH   = 64;
    localparam int unsigned SEED_WIDTH  = 64;
    localparam int unsigned COUNT_WIDTH = 16;
    localparam int unsigned DATA_WIDTH  = 64;
    localparam int unsigned ADDR_WIDTH  = 4;

    localparam int unsigned SHIFT_A = 23;
    localparam int unsigned SHIFT_B = 17;
    localparam int unsigned SHIFT_C = 26;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    localparam logic REG_SEED_FIRST  = 1'b0;
    localparam logic REG_SEED_SECOND = 1'b1;

    localparam logic [SEED_WIDTH-1:0] SEED_FIRST_RESET  = SEED_WIDTH'(1);
    localparam logic [SEED_WIDTH-1:0] SEED_SECOND_RESET = SEED_WIDTH'(2);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_PUT
    } state_t;

    typedef struct packed {
        logic load_seed;
        logic load_count;
        logic step;
        logic capture;
    } dp_cmd_t;

    typedef struct packed {
        logic in_count_zero;
        logic count_last;
    } dp_stat_t;

endpackage

// ----- hdl/xs128p_cfg.sv -----
module xs128p_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [xs128p_pkg::ADDR_WIDTH-1:0]    paddr,
    input  logic [xs128p_pkg::DATA_WIDTH-1:0]    pwdata,
    output logic [xs128p_pkg::DATA_WIDTH-1:0]    prdata,
    output logic                                 pready,
    output logic [xs128p_pkg::SEED_WIDTH-1:0]    seed_first,
    output logic [xs128p_pkg::SEED_WIDTH-1:0]    seed_second
);

    logic [xs128p_pkg::SEED_WIDTH-1:0] seed_first_reg;
    logic [xs128p_pkg::SEED_WIDTH-1:0] seed_second_reg;
    logic                              wr_en;
    logic                              reg_sel;

    // 8-byte registers; bit 3 picks the register
    assign reg_sel = paddr[3];
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_first_reg  <= xs128p_pkg::SEED_FIRST_RESET;
            seed_second_reg <= xs128p_pkg::SEED_SECOND_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                xs128p_pkg::REG_SEED_FIRST:  seed_first_reg  <= pwdata;
                xs128p_pkg::REG_SEED_SECOND: seed_second_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            xs128p_pkg::REG_SEED_FIRST:  prdata = seed_first_reg;
            xs128p_pkg::REG_SEED_SECOND: prdata = seed_second_reg;
            default:                     prdata = '0;
        endcase
    end

    assign seed_first  = seed_first_reg;
    assign seed_second = seed_second_reg;

endmodule

// ----- hdl/xs128p_dp.sv -----
module xs128p_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  xs128p_pkg::dp_cmd_t                   cmd,
    output xs128p_pkg::dp_stat_t                  stat,
    input  logic [xs128p_pkg::COUNT_WIDTH-1:0]    step_count,
    input  logic [xs128p_pkg::SEED_WIDTH-1:0]     seed_first,
    input  logic [xs128p_pkg::SEED_WIDTH-1:0]     seed_second,
    output logic [xs128p_pkg::OUT_WIDTH-1:0]      state_low_word,
    output logic [xs128p_pkg::OUT_WIDTH-1:0]      state_high_word,
    output logic [xs128p_pkg::OUT_WIDTH-1:0]      random_sum
);

    localparam int unsigned W = xs128p_pkg::WORD_WIDTH;

    logic [W-1:0]                           first_reg;
    logic [W-1:0]                           first_next;
    logic [W-1:0]                           second_reg;
    logic [W-1:0]                           second_next;
    logic [xs128p_pkg::COUNT_WIDTH-1:0]     count_reg;
    logic [xs128p_pkg::COUNT_WIDTH-1:0]     count_next;
    logic [W-1:0]                           mix;
    logic [W-1:0]                           step_second;
    logic [W-1:0]                           sum;
    logic [xs128p_pkg::OUT_WIDTH-1:0]       low_reg;
    logic [xs128p_pkg::OUT_WIDTH-1:0]       high_reg;
    logic [xs128p_pkg::OUT_WIDTH-1:0]       sum_reg;

    // one xorshift128+ update
    assign mix         = first_reg ^ (first_reg << xs128p_pkg::SHIFT_A);
    assign step_second = mix ^ second_reg ^ (mix >> xs128p_pkg::SHIFT_B)
                         ^ (second_reg >> xs128p_pkg::SHIFT_C);
    assign sum         = first_reg + second_reg;

    always_comb
    begin
        first_next  = first_reg;
        second_next = second_reg;
        count_next  = count_reg;
        if (cmd.load_seed)
        begin
            first_next  = seed_first[W-1:0];
            second_next = seed_second[W-1:0];
        end
        else if (cmd.step)
        begin
            first_next  = second_reg;
            second_next = step_second;
        end
        if (cmd.load_count)
            count_next = step_count;
        else if (cmd.step)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= '0;
            second_reg <= '0;
        end
        else
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        if (cmd.capture)
        begin
            low_reg  <= xs128p_pkg::OUT_WIDTH'(first_reg);
            high_reg <= xs128p_pkg::OUT_WIDTH'(second_reg);
            sum_reg  <= xs128p_pkg::OUT_WIDTH'(sum);
        end
    end

    assign stat.in_count_zero = (step_count == '0);
    assign stat.count_last    = (count_reg == xs128p_pkg::COUNT_WIDTH'(1));

    assign state_low_word  = low_reg;
    assign state_high_word = high_reg;
    assign random_sum      = sum_reg;

endmodule

// ----- hdl/xs128p_ctrl.sv -----
`include "assert_macros.svh"

module xs128p_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  opcode,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  xs128p_pkg::dp_stat_t  stat,
    output xs128p_pkg::dp_cmd_t   cmd
);

    xs128p_pkg::state_t state_reg;
    xs128p_pkg::state_t state_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               accept;
    logic               out_free;

    assign accept   = in_valid & in_ready;
    assign out_free = ~out_valid_reg | out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            xs128p_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == xs128p_pkg::OP_ADVANCE && !stat.in_count_zero)
                        state_next = xs128p_pkg::ST_RUN;
                    else
                        state_next = xs128p_pkg::ST_PUT;
                end
            end
            xs128p_pkg::ST_RUN:
            begin
                if (stat.count_last)
                    state_next = xs128p_pkg::ST_PUT;
            end
            xs128p_pkg::ST_PUT:
            begin
                if (out_free)
                    state_next = xs128p_pkg::ST_IDLE;
            end
            default: state_next = xs128p_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        out_valid_next = out_valid_reg & ~out_ready;
        case (state_reg)
            xs128p_pkg::ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.load_count = accept;
                cmd.load_seed  = accept & (opcode == xs128p_pkg::OP_LOAD);
            end
            xs128p_pkg::ST_RUN:
            begin
                cmd.step = 1'b1;
            end
            xs128p_pkg::ST_PUT:
            begin
                cmd.capture = out_free;
                if (out_free)
                    out_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= xs128p_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `XS_ASSERT(a_capture_free, cmd.capture |-> (!out_valid_reg || out_ready), "result overwritten")
    `XS_ASSERT(a_step_alone, cmd.step |-> (!cmd.load_seed && !cmd.capture), "step clashes")
    `XS_ASSERT(a_load_put, (accept && opcode == xs128p_pkg::OP_LOAD) |=> (state_reg == xs128p_pkg::ST_PUT), "load skipped result")
    `XS_ASSERT(a_capture_valid, cmd.capture |=> out_valid_reg, "capture lost valid")
    `XS_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_valid_reg, "valid out of reset")

endmodule

// ----- hdl/xorshift128_plus_generator_unit.sv -----
// xorshift128+ generator. A load beat (opcode 0) copies the seed registers into the
// state and presents its result once the PUT state has captured it in the output
// register. An advance beat runs one update per cycle in the RUN state, step_count
// updates in all (none for a count of zero), before PUT captures its result. The
// single update unit works on one item at a time, and a new beat is taken the cycle
// after the previous result is captured in the output register, while that result may
// still wait for out_ready. A result held by out_ready stalls the following item only
// when that item is ready to capture.
// Seeds are 64-bit APB registers at 0x0 (seed_first) and 0x8 (seed_second); write them
// only while the block is idle.
module xorshift128_plus_generator_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [xs128p_pkg::ADDR_WIDTH-1:0]    paddr,
    input  logic [xs128p_pkg::DATA_WIDTH-1:0]    pwdata,
    output logic [xs128p_pkg::DATA_WIDTH-1:0]    prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 opcode,
    input  logic [xs128p_pkg::COUNT_WIDTH-1:0]   step_count,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [xs128p_pkg::OUT_WIDTH-1:0]     state_low_word,
    output logic [xs128p_pkg::OUT_WIDTH-1:0]     state_high_word,
    output logic [xs128p_pkg::OUT_WIDTH-1:0]     random_sum
);

    logic [xs128p_pkg::SEED_WIDTH-1:0] seed_first;
    logic [xs128p_pkg::SEED_WIDTH-1:0] seed_second;
    xs128p_pkg::dp_cmd_t               cmd;
    xs128p_pkg::dp_stat_t              stat;

    xs128p_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .seed_first  (seed_first),
        .seed_second (seed_second)
    );

    xs128p_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    xs128p_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .step_count      (step_count),
        .seed_first      (seed_first),
        .seed_second     (seed_second),
        .state_low_word  (state_low_word),
        .state_high_word (state_high_word),
        .random_sum      (random_sum)
    );

endmodule
